>>> rtl/core/tea_pkg.sv
`default_nettype none

package tea_pkg;

    localparam int          TEA_ROUNDS   = 8;
    localparam logic [31:0] TEA_DELTA    = 32'h0e37_79b9;
    localparam int          TEA_SHL      = 4;
    localparam int          TEA_SHR      = 5;

    localparam logic        CMD_ENCRYPT  = 1'b0;
    localparam logic        CMD_DECRYPT  = 1'b1;

    // One block in flight: operation, the two halves and the last flag
    typedef struct packed {
        logic        cmd;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } tea_item_t;

    // TEA round function with arithmetic right shift
    function automatic logic [31:0] tea_mix(
        input logic [31:0] w,
        input logic [31:0] sum,
        input logic [31:0] k
    );
        logic [31:0] shl_term;
        logic [31:0] shr_term;
        shl_term = (w << TEA_SHL) + k;
        shr_term = 32'($signed(w) >>> TEA_SHR) + k;
        return shl_term ^ (w + sum) ^ shr_term;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tea_if.sv
`default_nettype none

// Block input channel
interface tea_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] data_block;
    logic        block_last;

    modport source (output valid, output cmd, output data_block, output block_last,
                    input ready);
    modport sink   (input valid, input cmd, input data_block, input block_last,
                    output ready);
endinterface

// Result output channel
interface tea_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_block;
    logic        result_last;

    modport source (output valid, output result_block, output result_last,
                    input ready);
    modport sink   (input valid, input result_block, input result_last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/tea_half_round.sv
`default_nettype none

module tea_half_round
    import tea_pkg::*;
#(
    parameter int ROUNDS = TEA_ROUNDS,
    parameter int STAGE  = 0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] key,
    input  wire logic        up_valid,
    output      logic        up_ready,
    input  wire tea_item_t   up_item,
    output      logic        dn_valid,
    input  wire logic        dn_ready,
    output      tea_item_t   dn_item
);

    localparam int          RND        = STAGE / 2;
    localparam bit          SECOND     = (STAGE % 2) == 1;
    localparam logic [31:0] SUM_ENC    = 32'(64'(TEA_DELTA) * 64'(RND + 1));
    localparam logic [31:0] SUM_DEC    = 32'(64'(TEA_DELTA) * 64'(ROUNDS - RND));

    logic        valid_reg;
    tea_item_t   item_reg;
    tea_item_t   item_next;
    logic [31:0] sum;
    logic [31:0] src;
    logic [31:0] mix_val;
    logic        enc;

    // Pick sum and source half for this half round
    always_comb
    begin
        enc = (up_item.cmd == CMD_ENCRYPT);
        sum = enc ? SUM_ENC : SUM_DEC;
        if (SECOND)
            src = enc ? up_item.y : up_item.z;
        else
            src = enc ? up_item.z : up_item.y;
        mix_val = tea_mix(src, sum, key);
    end

    // Update one half: encrypt adds, decrypt subtracts
    always_comb
    begin
        item_next = up_item;
        if (SECOND)
        begin
            if (enc)
                item_next.z = up_item.z + mix_val;
            else
                item_next.y = up_item.y - mix_val;
        end
        else
        begin
            if (enc)
                item_next.y = up_item.y + mix_val;
            else
                item_next.z = up_item.z - mix_val;
        end
    end

    // Take a new item when empty or when the next stage drains this one
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // Hold payload unless a transfer loads it
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

>>> rtl/core/tea_block_cipher_8_round.sv
`default_nettype none

// Channel   | Dir | Payload                           | Transfer
// in_blk    | in  | cmd, data_block[63:0], block_last | valid && ready
// out_blk   | out | result_block[63:0], result_last   | valid && ready
// key_*     | in  | key_wdata[31:0]                   | key_we
//
// There is one register stage per half round, each holding one round-function
// evaluation and the 32-bit add or subtract that updates one half.
// One block enters per cycle while out_blk is ready; stages fill bubbles while the output stalls.
// rst_n clears all stage valid bits and the key; payload registers are not reset.
// A stall at out_blk backs up one stage at a time; nothing is lost or repeated.

module tea_block_cipher_8_round
    import tea_pkg::*;
#(
    parameter int ROUNDS = TEA_ROUNDS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tea_in_if.sink           in_blk,
    tea_out_if.source        out_blk,
    input  wire logic        key_we,
    input  wire logic [31:0] key_wdata
);

    localparam int STAGES = 2 * ROUNDS;

    logic [31:0] key_reg;
    logic        valid  [STAGES+1];
    logic        ready  [STAGES+1];
    tea_item_t   item   [STAGES+1];

    // Latch the key on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else if (key_we)
            key_reg <= key_wdata;
    end

    // Split the input block into halves
    assign valid[0]     = in_blk.valid;
    assign in_blk.ready = ready[0];
    always_comb
    begin
        item[0].cmd  = in_blk.cmd;
        item[0].y    = in_blk.data_block[63:32];
        item[0].z    = in_blk.data_block[31:0];
        item[0].last = in_blk.block_last;
    end

    // Chain the half-round stages
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        tea_half_round #(
            .ROUNDS (ROUNDS),
            .STAGE  (s)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key_reg),
            .up_valid (valid[s]),
            .up_ready (ready[s]),
            .up_item  (item[s]),
            .dn_valid (valid[s+1]),
            .dn_ready (ready[s+1]),
            .dn_item  (item[s+1])
        );
    end

    // Drive the result from the last stage
    assign out_blk.valid        = valid[STAGES];
    assign ready[STAGES]        = out_blk.ready;
    assign out_blk.result_block = {item[STAGES].y, item[STAGES].z};
    assign out_blk.result_last  = item[STAGES].last;

endmodule

`default_nettype wire

>>> rtl/core/tea_checker.sv
`default_nettype none

module tea_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_block,
    input wire logic        out_last
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_block) && $stable(out_last))
        else $error("result payload changed while stalled");

    // Input backpressure only when a full pipeline meets a stalled output
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // An open output drains every stage, so the input is open too
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output ready");

    // Nothing leaves right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered out of reset");

endmodule

bind tea_block_cipher_8_round tea_checker u_tea_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_blk.ready),
    .out_valid (out_blk.valid),
    .out_ready (out_blk.ready),
    .out_block (out_blk.result_block),
    .out_last  (out_blk.result_last)
);

`default_nettype wire

>>> tb/tea_cipher_checker.sv
`timescale 1ns / 100ps

module tea_cipher_checker
    import tea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tea_in_if           in_mon,
    tea_out_if          out_mon,
    input  logic        key_we,
    input  logic [31:0] key_wdata,
    output int          mismatch_count,
    output int          results_pending
);

    typedef struct {
        logic [63:0] block;
        logic        last;
    } cipher_result_t;

    cipher_result_t ciphered_blocks[$];
    cipher_result_t oldest;
    logic [31:0]    cipher_key;

    initial
    begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    // One half-round term: shifted copies of w plus key, mixed with w plus sum
    function automatic logic [31:0] half_round_term(
        input logic [31:0] w,
        input logic [31:0] sum,
        input logic [31:0] k
    );
        logic [31:0] sra_w;
        sra_w = {{TEA_SHR{w[31]}}, w[31:TEA_SHR]};
        return ((w << TEA_SHL) + k) ^ (w + sum) ^ (sra_w + k);
    endfunction

    // Run the full round sequence in either direction
    function automatic logic [63:0] tea_cipher_block(
        input logic        cmd,
        input logic [63:0] blk,
        input logic [31:0] k
    );
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        int          r;
        y = blk[63:32];
        z = blk[31:0];
        if (cmd == CMD_ENCRYPT)
        begin
            sum = '0;
            for (r = 0; r < TEA_ROUNDS; r++)
            begin
                sum = sum + TEA_DELTA;
                y   = y + half_round_term(z, sum, k);
                z   = z + half_round_term(y, sum, k);
            end
        end
        else
        begin
            sum = 32'(TEA_DELTA * TEA_ROUNDS);
            for (r = 0; r < TEA_ROUNDS; r++)
            begin
                z   = z - half_round_term(y, sum, k);
                y   = y - half_round_term(z, sum, k);
                sum = sum - TEA_DELTA;
            end
        end
        return {y, z};
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns  MISMATCH: %s", $time, what);
        mismatch_count++;
    endtask

    // Retire results against the oldest prediction, then queue new transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key = '0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (ciphered_blocks.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with no block outstanding",
                                              out_mon.result_block));
                end
                else
                begin
                    oldest = ciphered_blocks.pop_front();
                    if (out_mon.result_block !== oldest.block)
                        report_mismatch($sformatf("result_block %h, predicted %h",
                                                  out_mon.result_block, oldest.block));
                    if (out_mon.result_last !== oldest.last)
                        report_mismatch($sformatf("result_last %b, predicted %b",
                                                  out_mon.result_last, oldest.last));
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                oldest.block = tea_cipher_block(in_mon.cmd, in_mon.data_block, cipher_key);
                oldest.last  = in_mon.block_last;
                ciphered_blocks.push_back(oldest);
            end
            if (key_we)
                cipher_key = key_wdata;
            results_pending = ciphered_blocks.size();
        end
    end

endmodule

>>> tb/tb_tea_block_cipher_8_round.sv
`timescale 1ns / 100ps

module tb_tea_block_cipher_8_round;
    import tea_pkg::*;

    localparam int LATENCY     = 2 * TEA_ROUNDS;
    localparam int LONG_STALL  = 80;
    localparam int SEGMENT_LEN = 158;

    localparam logic [63:0] DIRECTED_BLOCKS [6] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_8000_0000,
        64'h7FFF_FFFF_7FFF_FFFF,
        64'h0000_0000_8000_0000,
        64'h0123_4567_89AB_CDEF
    };

    localparam logic [31:0] CORNER_WORDS [4] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF
    };

    logic        clk;
    logic        rst_n;
    logic        key_we;
    logic [31:0] key_wdata;
    int          mismatch_count;
    int          results_pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_request;

    tea_in_if  blk_in();
    tea_out_if blk_out();

    tea_block_cipher_8_round i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_blk    (blk_in),
        .out_blk   (blk_out),
        .key_we    (key_we),
        .key_wdata (key_wdata)
    );

    tea_cipher_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (blk_in),
        .out_mon         (blk_out),
        .key_we          (key_we),
        .key_wdata       (key_wdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int stall_taken;
        hold_left   = 0;
        stall_taken = 0;
        blk_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_taken != stall_request)
            begin
                hold_left   = LONG_STALL;
                stall_taken = stall_request;
            end
            if (hold_left > 0)
            begin
                blk_out.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                blk_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one block and hold it until the transfer
    task automatic send_block(input logic cmd, input logic [63:0] blk, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            blk_in.valid <= 1'b0;
            @(posedge clk);
        end
        blk_in.valid      <= 1'b1;
        blk_in.cmd        <= cmd;
        blk_in.data_block <= blk;
        blk_in.block_last <= last;
        do
            @(posedge clk);
        while (!blk_in.ready);
    endtask

    // Drop valid and wait until every outstanding block has come back
    task automatic drain;
        blk_in.valid <= 1'b0;
        do
            @(negedge clk);
        while (results_pending != 0);
        @(posedge clk);
    endtask

    task automatic write_key(input logic [31:0] value);
        drain();
        key_we    <= 1'b1;
        key_wdata <= value;
        @(posedge clk);
        key_we    <= 1'b0;
    endtask

    task automatic send_directed;
        int i;
        int c;
        for (i = 0; i < 6; i++)
            for (c = 0; c < 2; c++)
                send_block(c ? CMD_DECRYPT : CMD_ENCRYPT, DIRECTED_BLOCKS[i],
                           1'((i + c) % 2));
    endtask

    // Random blocks; some halves forced to zero, all-ones, sign-bit and largest-positive corners
    task automatic send_random(input int count);
        logic [31:0] y;
        logic [31:0] z;
        int          n;
        for (n = 0; n < count; n++)
        begin
            y = $urandom();
            z = $urandom();
            if ($urandom_range(0, 7) == 0)
                y = CORNER_WORDS[$urandom_range(0, 3)];
            if ($urandom_range(0, 7) == 0)
                z = CORNER_WORDS[$urandom_range(0, 3)];
            send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT, {y, z},
                       $urandom_range(0, 7) == 0);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [31:0] segment_keys [6];
        int          seg;
        segment_keys[0] = 32'h8000_0000;
        segment_keys[1] = $urandom();
        segment_keys[2] = 32'h0000_0001;
        segment_keys[3] = $urandom();
        segment_keys[4] = 32'h7FFF_FFFF;
        segment_keys[5] = $urandom();

        send_idle_pct = 28;
        recv_idle_pct = 56;
        stall_request = 0;
        rst_n             <= 1'b0;
        key_we            <= 1'b0;
        key_wdata         <= '0;
        blk_in.valid      <= 1'b0;
        blk_in.cmd        <= CMD_ENCRYPT;
        blk_in.data_block <= '0;
        blk_in.block_last <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under the reset key, then the all-ones key
        send_directed();
        write_key(32'hFFFF_FFFF);
        send_directed();

        for (seg = 0; seg < 6; seg++)
        begin
            write_key(segment_keys[seg]);
            if (seg == 2)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 28;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 1 || seg == 5)
                stall_request++;
            send_random(SEGMENT_LEN);
        end

        drain();
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
